// ===== design/clp_pkg.sv =====
`default_nettype none

package clp_pkg;

    // field widths of the request and response words
    localparam int CMD_BITS    = 3;
    localparam int VALUE_BITS  = 32;
    localparam int POS_BITS    = 6;
    localparam int COUNT_BITS  = 7;
    localparam int STATUS_BITS = 2;

    localparam int DEPTH_DEF     = 64;
    localparam int WORD_BITS_DEF = 32;

    localparam logic [CMD_BITS-1:0] CMD_START   = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_ADVANCE = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_INSERT  = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_ATTACH  = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_REMOVE  = 3'd4;
    localparam logic [CMD_BITS-1:0] CMD_READ    = 3'd5;

    localparam logic [STATUS_BITS-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_NOCUR  = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_BEYOND = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic decode;
        logic rd_up;
        logic wr_up;
        logic wr_new;
        logic rd_dn;
        logic wr_dn;
        logic dn_done;
        logic rd_pos;
        logic cap_pos;
        logic rd_cur;
        logic fin;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic go_ins;
        logic go_rem;
        logic go_rd;
        logic up_more;
        logic dn_more;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== design/clp_if.sv =====
`default_nettype none

interface clp_req_if;
    logic                             valid;
    logic                             ready;
    logic [clp_pkg::CMD_BITS-1:0]     command;
    logic [clp_pkg::VALUE_BITS-1:0]   value;
    logic [clp_pkg::POS_BITS-1:0]     position;

    modport source (output valid, output command, output value, output position,
                    input ready);
    modport sink   (input valid, input command, input value, input position,
                    output ready);
endinterface

interface clp_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [clp_pkg::VALUE_BITS-1:0]   current_value;
    logic                             has_current;
    logic [clp_pkg::COUNT_BITS-1:0]   count;
    logic [clp_pkg::VALUE_BITS-1:0]   read_value;
    logic [clp_pkg::STATUS_BITS-1:0]  status;

    modport source (output valid, output current_value, output has_current,
                    output count, output read_value, output status, input ready);
    modport sink   (input valid, input current_value, input has_current,
                    input count, input read_value, input status, output ready);
endinterface

`default_nettype wire

// ===== design/clp_ram.sv =====
`default_nettype none

module clp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold the last read word until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/clp_ctrl.sv =====
`default_nettype none

module clp_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire clp_pkg::t_dp_stat i_st,
    output clp_pkg::t_dp_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_UP_RD   = 4'd2;
    localparam logic [3:0] S_UP_WR   = 4'd3;
    localparam logic [3:0] S_NEW_WR  = 4'd4;
    localparam logic [3:0] S_DN_RD   = 4'd5;
    localparam logic [3:0] S_DN_WR   = 4'd6;
    localparam logic [3:0] S_POS_RD  = 4'd7;
    localparam logic [3:0] S_POS_CAP = 4'd8;
    localparam logic [3:0] S_CUR_RD  = 4'd9;
    localparam logic [3:0] S_FIN     = 4'd10;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_fin_ok;

    assign w_fin_ok = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                if (i_st.go_ins) begin
                    n_state = S_UP_RD;
                end else if (i_st.go_rem) begin
                    n_state = S_DN_RD;
                end else if (i_st.go_rd) begin
                    n_state = S_POS_RD;
                end else begin
                    n_state = S_CUR_RD;
                end
            end
            S_UP_RD: begin
                if (i_st.up_more) begin
                    o_cmd.rd_up = 1'b1;
                    n_state     = S_UP_WR;
                end else begin
                    n_state = S_NEW_WR;
                end
            end
            S_UP_WR: begin
                o_cmd.wr_up = 1'b1;
                n_state     = S_UP_RD;
            end
            S_NEW_WR: begin
                o_cmd.wr_new = 1'b1;
                n_state      = S_CUR_RD;
            end
            S_DN_RD: begin
                if (i_st.dn_more) begin
                    o_cmd.rd_dn = 1'b1;
                    n_state     = S_DN_WR;
                end else begin
                    o_cmd.dn_done = 1'b1;
                    n_state       = S_CUR_RD;
                end
            end
            S_DN_WR: begin
                o_cmd.wr_dn = 1'b1;
                n_state     = S_DN_RD;
            end
            S_POS_RD: begin
                o_cmd.rd_pos = 1'b1;
                n_state      = S_POS_CAP;
            end
            S_POS_CAP: begin
                o_cmd.cap_pos = 1'b1;
                n_state       = S_CUR_RD;
            end
            S_CUR_RD: begin
                o_cmd.rd_cur = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                // hold until the output register is free
                if (w_fin_ok) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.fin) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== design/clp_dp.sv =====
`default_nettype none

module clp_dp #(
    parameter int DEPTH     = clp_pkg::DEPTH_DEF,
    parameter int WORD_BITS = clp_pkg::WORD_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire clp_pkg::t_dp_cmd                  i_cmd,
    output clp_pkg::t_dp_stat                      o_st,
    input  wire logic [clp_pkg::CMD_BITS-1:0]      i_command,
    input  wire logic [clp_pkg::VALUE_BITS-1:0]    i_value,
    input  wire logic [clp_pkg::POS_BITS-1:0]      i_position,
    output logic      [clp_pkg::VALUE_BITS-1:0]    o_current_value,
    output logic                                   o_has_current,
    output logic      [clp_pkg::COUNT_BITS-1:0]    o_count,
    output logic      [clp_pkg::VALUE_BITS-1:0]    o_read_value,
    output logic      [clp_pkg::STATUS_BITS-1:0]   o_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > clp_pkg::POS_BITS) ? CW : clp_pkg::POS_BITS;

    logic [clp_pkg::CMD_BITS-1:0]    r_cmd;
    logic [WORD_BITS-1:0]            r_word;
    logic [clp_pkg::POS_BITS-1:0]    r_pos;
    logic [CW-1:0]                   r_count;
    logic [CW-1:0]                   r_cursor;
    logic [CW-1:0]                   r_idx;
    logic [CW-1:0]                   r_tgt;
    logic [clp_pkg::STATUS_BITS-1:0] r_status;
    logic [WORD_BITS-1:0]            r_rd;

    logic [clp_pkg::VALUE_BITS-1:0]  r_o_cur;
    logic                            r_o_has;
    logic [clp_pkg::COUNT_BITS-1:0]  r_o_cnt;
    logic [clp_pkg::VALUE_BITS-1:0]  r_o_rd;
    logic [clp_pkg::STATUS_BITS-1:0] r_o_st;

    logic                 w_have, w_full, w_pos_ok, w_is_ins;
    logic [XW-1:0]        w_pos_x;
    logic [CW-1:0]        w_idx_dec, w_idx_inc;
    logic [CW:0]          w_idx_inc_x;
    logic                 w_we, w_re;
    logic [AW-1:0]        w_waddr, w_raddr;
    logic [WORD_BITS-1:0] w_wdata, w_q;
    logic [clp_pkg::STATUS_BITS-1:0] w_dec_status;

    assign w_have    = r_cursor < r_count;
    assign w_full    = r_count >= CW'(DEPTH);
    assign w_pos_x   = XW'(r_pos);
    assign w_pos_ok  = (w_pos_x < XW'(r_count)) && (w_pos_x < XW'(DEPTH));
    assign w_is_ins  = (r_cmd == clp_pkg::CMD_INSERT) || (r_cmd == clp_pkg::CMD_ATTACH);
    assign w_idx_dec = r_idx - CW'(1);
    assign w_idx_inc = r_idx + CW'(1);
    assign w_idx_inc_x = {1'b0, r_idx} + (CW + 1)'(1);

    assign o_st.go_ins  = w_is_ins && !w_full;
    assign o_st.go_rem  = (r_cmd == clp_pkg::CMD_REMOVE) && w_have;
    assign o_st.go_rd   = (r_cmd == clp_pkg::CMD_READ) && w_pos_ok;
    assign o_st.up_more = r_idx > r_tgt;
    assign o_st.dn_more = w_idx_inc_x < {1'b0, r_count};

    // status of the word being decoded
    always_comb begin
        w_dec_status = clp_pkg::ST_OK;
        case (r_cmd)
            clp_pkg::CMD_ADVANCE, clp_pkg::CMD_REMOVE: begin
                if (!w_have) begin
                    w_dec_status = clp_pkg::ST_NOCUR;
                end
            end
            clp_pkg::CMD_INSERT, clp_pkg::CMD_ATTACH: begin
                if (w_full) begin
                    w_dec_status = clp_pkg::ST_FULL;
                end
            end
            clp_pkg::CMD_READ: begin
                if (!w_pos_ok) begin
                    w_dec_status = clp_pkg::ST_BEYOND;
                end
            end
            default: begin
            end
        endcase
    end

    // store port steering
    always_comb begin
        w_we    = i_cmd.wr_up || i_cmd.wr_dn || i_cmd.wr_new;
        w_waddr = r_idx[AW-1:0];
        w_wdata = w_q;
        if (i_cmd.wr_new) begin
            w_waddr = r_tgt[AW-1:0];
            w_wdata = r_word;
        end
        w_re    = i_cmd.rd_up || i_cmd.rd_dn || i_cmd.rd_pos || i_cmd.rd_cur;
        w_raddr = r_cursor[AW-1:0];
        if (i_cmd.rd_up) begin
            w_raddr = w_idx_dec[AW-1:0];
        end else if (i_cmd.rd_dn) begin
            w_raddr = w_idx_inc[AW-1:0];
        end else if (i_cmd.rd_pos) begin
            w_raddr = w_pos_x[AW-1:0];
        end
    end

    clp_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_q)
    );

    // count and cursor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cursor <= '0;
        end else begin
            if (i_cmd.decode) begin
                if (r_cmd == clp_pkg::CMD_START) begin
                    r_cursor <= '0;
                end else if ((r_cmd == clp_pkg::CMD_ADVANCE) && w_have) begin
                    r_cursor <= r_cursor + CW'(1);
                end
            end
            if (i_cmd.wr_new) begin
                r_cursor <= r_tgt;
                r_count  <= r_count + CW'(1);
            end
            if (i_cmd.dn_done) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // working and result words
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_command;
            r_word <= WORD_BITS'(i_value);
            r_pos  <= i_position;
        end
        if (i_cmd.decode) begin
            r_status <= w_dec_status;
            r_rd     <= '0;
            r_idx    <= (r_cmd == clp_pkg::CMD_REMOVE) ? r_cursor : r_count;
            case (r_cmd)
                clp_pkg::CMD_INSERT: begin
                    // no current item: new word goes to the front
                    r_tgt <= w_have ? r_cursor : '0;
                end
                clp_pkg::CMD_ATTACH: begin
                    // no current item: new word goes to the end
                    r_tgt <= w_have ? (r_cursor + CW'(1)) : r_count;
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.wr_up) begin
            r_idx <= w_idx_dec;
        end
        if (i_cmd.wr_dn) begin
            r_idx <= w_idx_inc;
        end
        if (i_cmd.cap_pos) begin
            r_rd <= w_q;
        end
        if (i_cmd.fin) begin
            r_o_has <= w_have;
            r_o_cur <= w_have ? clp_pkg::VALUE_BITS'(w_q) : '0;
            r_o_cnt <= clp_pkg::COUNT_BITS'(r_count);
            r_o_rd  <= clp_pkg::VALUE_BITS'(r_rd);
            r_o_st  <= r_status;
        end
    end

    assign o_current_value = r_o_cur;
    assign o_has_current   = r_o_has;
    assign o_count         = r_o_cnt;
    assign o_read_value    = r_o_rd;
    assign o_status        = r_o_st;

endmodule

`default_nettype wire

// ===== design/cursor_ordered_list.sv =====
// Each word passes through accept, decode, any entry moves, a read of the current
//   entry and a finish that waits until the result register is free; a read within
//   the count first reads and captures the word at the given position.
// A new word is taken only while the controller is idle, so one word is in work at
//   a time; insert, attach and remove move entries one by one, each a read, then a write.
// Reset (synchronous, active low) clears the count, the cursor and the handshake
//   state; the store is not cleared and needs no clearing pass.
`default_nettype none

module cursor_ordered_list #(
    parameter int DEPTH     = clp_pkg::DEPTH_DEF,
    parameter int WORD_BITS = clp_pkg::WORD_BITS_DEF
) (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    clp_req_if.sink     i_req,
    clp_rsp_if.source   o_rsp
);

    clp_pkg::t_dp_cmd  w_cmd;
    clp_pkg::t_dp_stat w_st;

    clp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_st        (w_st),
        .o_cmd       (w_cmd)
    );

    clp_dp #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_st            (w_st),
        .i_command       (i_req.command),
        .i_value         (i_req.value),
        .i_position      (i_req.position),
        .o_current_value (o_rsp.current_value),
        .o_has_current   (o_rsp.has_current),
        .o_count         (o_rsp.count),
        .o_read_value    (o_rsp.read_value),
        .o_status        (o_rsp.status)
    );

    // a refused insert or attach only happens on a full store
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == clp_pkg::ST_FULL)) |->
        (o_rsp.count == clp_pkg::COUNT_BITS'(DEPTH)))
        else $error("full status with a store that is not full");

    a_no_cur_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.has_current) |-> (o_rsp.current_value == '0))
        else $error("current word not zero without a current item");

    a_nocur_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == clp_pkg::ST_NOCUR)) |-> !o_rsp.has_current)
        else $error("no-current status while a current item exists");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (!i_req.ready && w_cmd.decode))
        else $error("accepted word not decoded in the following cycle");

endmodule

`default_nettype wire
